FILE: sv/stbs_pkg.sv
// stbs_pkg: shared types and constants of the sorted table binary search unit
// used by sorted_table_binary_search_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_BITS  = 32;

	localparam int CNT_W        = 11;
	localparam int POS_W        = 11;
	localparam int OUT_TDATA_W  = ((POS_W + 7) / 8) * 8;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;
	localparam int REG_IDX_W    = 1;

	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b0;
	localparam logic [CNT_W-1:0]     COUNT_RESET     = 11'd1;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CHECK
	} stbs_state_t;

endpackage

`default_nettype wire

FILE: sv/sorted_table_binary_search_unit.sv
// sorted_table_binary_search_unit: lower-bound search over a table of signed words
// depends on stbs_pkg and stbs_ram
//
// input stream s_*: s_tuser is the request type (0 write entry, 1 search),
// s_tdata holds entry_index in the low bits and data_value above it.
// a write transfer stores one entry and gives no result.
// a search transfer walks a halving search over the first entry_count entries,
// one table read and one signed compare per cycle through the ram read port;
// a search takes its transfer, then the probe steps (none for an empty table), then the check step.
// output stream m_*: m_tuser is the found flag, m_tdata the position.
// the result sits in an output register; while the receiver stalls the unit
// still takes write transfers and runs the next search, holding it in the
// check step until the output register is free.
// the apb port sets entry_count (byte address 0); searches saturate it to the table depth.
// reset clears the control state and sets entry_count to 1; the table contents
// are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search_unit #(
	parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = stbs_pkg::DEF_VALUE_BITS
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	// apb configuration
	input  wire                                          psel,
	input  wire                                          penable,
	input  wire                                          pwrite,
	input  wire  [stbs_pkg::APB_ADDR_W-1:0]              paddr,
	input  wire  [stbs_pkg::APB_DATA_W-1:0]              pwdata,
	output logic [stbs_pkg::APB_DATA_W-1:0]              prdata,
	output logic                                         pready,
	// input stream
	input  wire                                          s_tvalid,
	output logic                                         s_tready,
	// entry_index, data_value
	input  wire  [((($clog2(TABLE_DEPTH) + VALUE_BITS) + 7) / 8) * 8 - 1:0] s_tdata,
	// req_type
	input  wire                                          s_tuser,
	// output stream
	output logic                                         m_tvalid,
	input  wire                                          m_tready,
	// position
	output logic [stbs_pkg::OUT_TDATA_W-1:0]             m_tdata,
	// found
	output logic                                         m_tuser
);

	import stbs_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int NCL_W  = $clog2(TABLE_DEPTH + 1);
	localparam int PTR_W  = (CNT_W > NCL_W) ? CNT_W : NCL_W;

	stbs_state_t state_q, state_d;

	logic [CNT_W-1:0]      count_q;
	logic [PTR_W-1:0]      lo_q, hi_q, mid_q, n_q;
	logic [VALUE_BITS-1:0] key_q;
	logic                  m_valid_q, found_q;
	logic [POS_W-1:0]      pos_q;

	logic [ADDR_W-1:0]     in_index;
	logic [VALUE_BITS-1:0] in_value;
	logic                  accept, start, wr_en, rd_en, out_load, more, probe_lt, cfg_wr;
	logic [PTR_W-1:0]      n_cur, lo_n, hi_n, mid_n;
	logic [PTR_W:0]        mid_sum;
	logic [ADDR_W-1:0]     rd_addr;
	logic [VALUE_BITS-1:0] rd_data;

	assign in_index = s_tdata[ADDR_W-1:0];
	assign in_value = s_tdata[ADDR_W +: VALUE_BITS];

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1 -: REG_IDX_W] == REG_ENTRY_COUNT);

	always_comb begin
		if (paddr[APB_ADDR_W-1 -: REG_IDX_W] == REG_ENTRY_COUNT) begin
			prdata = {{(APB_DATA_W - CNT_W){1'b0}}, count_q};
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_wr) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	// effective count, saturated to the table depth
	always_comb begin
		if (PTR_W'(count_q) > PTR_W'(TABLE_DEPTH)) begin
			n_cur = PTR_W'(TABLE_DEPTH);
		end else begin
			n_cur = PTR_W'(count_q);
		end
	end

	// probe datapath
	assign probe_lt = $signed(rd_data) < $signed(key_q);

	always_comb begin
		if (state_q == ST_IDLE) begin
			lo_n = '0;
			hi_n = n_cur;
		end else if (probe_lt) begin
			lo_n = mid_q + PTR_W'(1);
			hi_n = hi_q;
		end else begin
			lo_n = lo_q;
			hi_n = mid_q;
		end
	end

	assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n   = mid_sum[PTR_W:1];
	assign more    = lo_n < hi_n;
	assign rd_addr = more ? mid_n[ADDR_W-1:0] : lo_n[ADDR_W-1:0];

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = more ? ST_PROBE : ST_CHECK;
				end
			end
			ST_PROBE: begin
				state_d = more ? ST_PROBE : ST_CHECK;
			end
			ST_CHECK: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				rd_en    = start;
			end
			ST_PROBE: begin
				rd_en = 1'b1;
			end
			ST_CHECK: begin
				out_load = !m_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;
	assign start  = accept && (s_tuser == REQ_SEARCH);
	assign wr_en  = accept && (s_tuser == REQ_WRITE)
		&& ({1'b0, in_index} < (ADDR_W + 1)'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= in_value;
			n_q   <= n_cur;
		end
		if (rd_en) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q <= (lo_q < n_q) && (rd_data == key_q);
			pos_q   <= lo_q[POS_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{(OUT_TDATA_W - POS_W){1'b0}}, pos_q};

	stbs_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (in_index),
		.wr_data (in_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

FILE: sv/stbs_ram.sv
// stbs_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire [WIDTH-1:0]          wr_data,
	input  wire                      rd_en,
	input  wire [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
